// ===== design/tqsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tqsl_pkg
// Shared constants for the tabular Q-learning / SARSA learner: table
// dimensions, register indexes and register reset values.
// ----------------------------------------------------------------------------
package tqsl_pkg;

	localparam int DEF_NUM_STATES  = 256;
	localparam int DEF_NUM_ACTIONS = 4;

	localparam int Q_W     = 32;
	localparam int CFG_W   = 20;
	localparam int CFG_IW  = 3;
	localparam int EPS_W   = 7;
	localparam int STEP_W  = 20;

	// Register indexes on the configuration port.
	localparam logic [CFG_IW-1:0] CFG_LEARNING_RATE = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_DISCOUNT      = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_EPSILON_START = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_ALGO_MODE     = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_STEP_LIMIT    = 3'd4;

	// Register reset values.
	localparam logic [15:0]       RST_LEARNING_RATE = 16'd6554;
	localparam logic [15:0]       RST_DISCOUNT      = 16'd58982;
	localparam logic [EPS_W-1:0]  RST_EPSILON       = 7'd10;
	localparam logic [STEP_W-1:0] RST_STEP_LIMIT    = 20'd500000;

	localparam logic [EPS_W-1:0]  EPS_FLOOR = 7'd2;
	localparam logic [STEP_W-1:0] STEP_MAX  = 20'hFFFFF;

	// Episode end codes.
	localparam logic [1:0] END_RUNNING  = 2'd0;
	localparam logic [1:0] END_TERMINAL = 2'd1;
	localparam logic [1:0] END_LIMIT    = 2'd2;

	localparam logic ALGO_QLEARN = 1'b0;
	localparam logic ALGO_SARSA  = 1'b1;

	localparam logic CMD_START    = 1'b0;
	localparam logic CMD_FEEDBACK = 1'b1;

endpackage

// ===== design/tabular_q_sarsa_learner_unit.sv =====
// ----------------------------------------------------------------------------
// tabular_q_sarsa_learner_unit
// Tabular Q-learning / SARSA learner with epsilon-greedy action choice over a
// Q16.16 Q table held in one row-wide synchronous memory.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------------
// input    | in        | in_valid / in_stall | command, start_state, next_state,
//          |           |                     | reward, terminal, explore_draw,
//          |           |                     | random_action
// output   | out       | out_valid/out_stall | action, current_state,
//          |           |                     | episode_end, epsilon_now,
//          |           |                     | updated_value
// config   | in        | cfg_we              | cfg_index, cfg_data
//
// A feedback item passes through two row reads of the Q memory, a row
// selection, two dependent multiplies with an error step between them, a
// write back and a choice of the next action; a start item makes its choice
// from the row read at acceptance, and ignored feedback goes straight to the
// final step. The next input transfer is taken once the result is issued.
// After reset a clearing pass writes zero to the table, one row a cycle, over
// all NUM_STATES rows; in_stall stays high during that pass.
// The result sits in an output register, so the next input transfer is taken
// while a result is still stalled; the block only waits at its final step,
// where it holds while the previous result stays stalled.
//
module tabular_q_sarsa_learner_unit
	import tqsl_pkg::*;
#(
	parameter int NUM_STATES  = DEF_NUM_STATES,
	parameter int NUM_ACTIONS = DEF_NUM_ACTIONS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    command,
	input  logic [7:0]              start_state,
	input  logic [7:0]              next_state,
	input  logic signed [Q_W-1:0]   reward,
	input  logic                    terminal,
	input  logic [EPS_W-1:0]        explore_draw,
	input  logic [1:0]              random_action,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              action,
	output logic [7:0]              current_state,
	output logic [1:0]              episode_end,
	output logic [EPS_W-1:0]        epsilon_now,
	output logic signed [Q_W-1:0]   updated_value
);

	localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int AW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;

	typedef logic [NUM_ACTIONS-1:0][Q_W-1:0] row_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_RDN,
		ST_SEL,
		ST_MULG,
		ST_ERR,
		ST_MULA,
		ST_WR,
		ST_QCH,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		K_START,
		K_FEED,
		K_IGNORE
	} kind_t;

	// Configuration registers.
	logic [15:0]        alpha_q;
	logic [15:0]        gamma_q;
	logic               mode_q;
	logic [STEP_W-1:0]  limit_q;

	// Architectural state.
	logic [SW-1:0]      state_q;
	logic [AW-1:0]      action_q;
	logic [EPS_W-1:0]   eps_q;
	logic [STEP_W-1:0]  step_q;
	logic               in_ep_q;

	// Sequencer and the item in flight.
	state_t             st_q;
	kind_t              kind_q;
	logic [SW-1:0]      s0_q;
	logic [SW-1:0]      sn_q;
	logic signed [Q_W-1:0] reward_q;
	logic               term_q;
	logic [EPS_W-1:0]   draw_q;
	logic [AW-1:0]      rnd_q;
	row_t               row_s_q;
	row_t               row_n_q;
	logic [AW-1:0]      ch_q;
	logic signed [Q_W-1:0] qn_q;
	logic signed [48:0] pg_q;
	logic signed [33:0] err_q;
	logic signed [50:0] pa_q;
	logic signed [Q_W-1:0] newv_q;

	// Clearing pass.
	logic               clr_busy_q;
	logic [SW-1:0]      clr_idx_q;

	// Output register.
	logic               out_valid_q;
	logic [1:0]         out_action_q;
	logic [7:0]         out_state_q;
	logic [1:0]         out_end_q;
	logic [EPS_W-1:0]   out_eps_q;
	logic signed [Q_W-1:0] out_value_q;

	// Q memory: one row of NUM_ACTIONS values per state.
	row_t               q_mem [NUM_STATES];
	row_t               rdata_q;
	logic [SW-1:0]      rd_addr;
	logic               wr_en;
	logic [SW-1:0]      wr_addr;
	row_t               wr_row;

	// State index reduced modulo NUM_STATES, a constant table over 8-bit codes.
	logic [SW-1:0]      smod [256];

	for (genvar k = 0; k < 256; k++) begin : g_smod
		assign smod[k] = SW'(k % NUM_STATES);
	end

	logic               accept;
	logic [AW-1:0]      rnd_mod;
	logic signed [Q_W-1:0] cur_val;
	logic signed [32:0] gq;
	logic signed [34:0] nv;
	logic signed [Q_W-1:0] nv_sat;
	logic [AW-1:0]      ch_rd;
	logic [AW-1:0]      ch_rn;
	logic signed [Q_W-1:0] max_rd;
	logic [STEP_W:0]    cnt;
	logic               out_free;

	// Epsilon-greedy choice: explore below epsilon, else first maximum, or the
	// random action when all values of the row are equal.
	function automatic logic [AW-1:0] choose(input row_t r, input logic [EPS_W-1:0] draw,
			input logic [EPS_W-1:0] eps, input logic [AW-1:0] rnd);
		logic signed [Q_W-1:0] best;
		logic [AW-1:0]         idx;
		logic                  eq;
		best = r[0];
		idx  = '0;
		eq   = 1'b1;
		for (int k = 1; k < NUM_ACTIONS; k++) begin
			if ($signed(r[k]) > best) begin
				best = r[k];
				idx  = AW'(k);
			end
			if (r[k] != r[0]) begin
				eq = 1'b0;
			end
		end
		if (draw < eps || eq) begin
			return rnd;
		end
		return idx;
	endfunction

	function automatic logic signed [Q_W-1:0] row_max(input row_t r);
		logic signed [Q_W-1:0] best;
		best = r[0];
		for (int k = 1; k < NUM_ACTIONS; k++) begin
			if ($signed(r[k]) > best) begin
				best = r[k];
			end
		end
		return best;
	endfunction

	assign in_stall  = (st_q != ST_IDLE) || clr_busy_q;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !(out_valid_q && out_stall);

	// The random action is at most 3; NUM_ACTIONS must be at least 2, which the
	// block itself does not check, so that one subtraction reduces it.
	always_comb begin
		if (int'(random_action) >= NUM_ACTIONS) begin
			rnd_mod = AW'(int'(random_action) - NUM_ACTIONS);
		end else begin
			rnd_mod = AW'(random_action);
		end
	end

	always_comb begin
		case (st_q)
			ST_IDLE: rd_addr = (command == CMD_START) ? smod[start_state] : state_q;
			default: rd_addr = sn_q;
		endcase
	end

	assign cur_val = row_s_q[action_q];
	assign gq      = 33'(pg_q >>> 16);
	assign nv      = 35'(cur_val) + 35'(pa_q >>> 16);
	assign ch_rd   = choose(rdata_q, draw_q, eps_q, rnd_q);
	assign ch_rn   = choose(row_n_q, draw_q, eps_q, rnd_q);
	assign max_rd  = row_max(rdata_q);
	assign cnt     = {1'b0, step_q} + 1'b1;

	always_comb begin
		if (nv > $signed(35'h0_7FFF_FFFF)) begin
			nv_sat = $signed(32'h7FFF_FFFF);
		end else if (nv < $signed(35'h7_8000_0000)) begin
			nv_sat = $signed(32'h8000_0000);
		end else begin
			nv_sat = Q_W'(nv);
		end
	end

	always_comb begin
		wr_row           = row_s_q;
		wr_row[action_q] = nv_sat;
		wr_en            = clr_busy_q || (st_q == ST_WR);
		wr_addr          = clr_busy_q ? clr_idx_q : state_q;
		if (clr_busy_q) begin
			wr_row = '0;
		end
	end

	// Memory: synchronous write, registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_addr] <= wr_row;
		end
		rdata_q <= q_mem[rd_addr];
	end

	// Item datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			s0_q     <= smod[start_state];
			sn_q     <= smod[next_state];
			reward_q <= reward;
			term_q   <= terminal;
			draw_q   <= explore_draw;
			rnd_q    <= rnd_mod;
		end
		case (st_q)
			ST_START: ch_q <= ch_rd;
			ST_RDN:   row_s_q <= rdata_q;
			ST_SEL: begin
				row_n_q <= rdata_q;
				ch_q    <= ch_rd;
				if (mode_q == ALGO_SARSA) begin
					qn_q <= term_q ? '0 : $signed(rdata_q[ch_rd]);
				end else begin
					qn_q <= max_rd;
				end
			end
			ST_MULG: pg_q <= qn_q * $signed({1'b0, gamma_q});
			ST_ERR:  err_q <= 34'(reward_q) + 34'(gq) - 34'(cur_val);
			ST_MULA: pa_q <= err_q * $signed({1'b0, alpha_q});
			ST_WR: begin
				newv_q <= nv_sat;
				// The next state row is the one just written: forward the new value.
				if (sn_q == state_q) begin
					row_n_q[action_q] <= nv_sat;
				end
			end
			ST_QCH: begin
				if (mode_q == ALGO_QLEARN) begin
					ch_q <= ch_rn;
				end
			end
			default: ;
		endcase
	end

	// Sequencer, registers, architectural state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			kind_q       <= K_IGNORE;
			alpha_q      <= RST_LEARNING_RATE;
			gamma_q      <= RST_DISCOUNT;
			mode_q       <= ALGO_QLEARN;
			limit_q      <= RST_STEP_LIMIT;
			state_q      <= '0;
			action_q     <= '0;
			eps_q        <= RST_EPSILON;
			step_q       <= '0;
			in_ep_q      <= 1'b0;
			clr_busy_q   <= 1'b1;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
			out_action_q <= '0;
			out_state_q  <= '0;
			out_end_q    <= END_RUNNING;
			out_eps_q    <= '0;
			out_value_q  <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == SW'(NUM_STATES - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_LEARNING_RATE: alpha_q <= cfg_data[15:0];
					CFG_DISCOUNT:      gamma_q <= cfg_data[15:0];
					CFG_EPSILON_START: eps_q   <= cfg_data[EPS_W-1:0];
					CFG_ALGO_MODE:     mode_q  <= cfg_data[0];
					CFG_STEP_LIMIT:    limit_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end

			// The final step sets valid itself when it issues a new result.
			if (out_valid_q && !out_stall && st_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_START) begin
							kind_q <= K_START;
							st_q   <= ST_START;
						end else if (in_ep_q) begin
							kind_q <= K_FEED;
							st_q   <= ST_RDN;
						end else begin
							kind_q <= K_IGNORE;
							st_q   <= ST_FIN;
						end
					end
				end
				ST_START: st_q <= ST_FIN;
				ST_RDN:   st_q <= ST_SEL;
				ST_SEL:   st_q <= ST_MULG;
				ST_MULG:  st_q <= ST_ERR;
				ST_ERR:   st_q <= ST_MULA;
				ST_MULA:  st_q <= ST_WR;
				ST_WR:    st_q <= ST_QCH;
				ST_QCH:   st_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
						case (kind_q)
							K_START: begin
								state_q      <= s0_q;
								step_q       <= '0;
								in_ep_q      <= 1'b1;
								action_q     <= ch_q;
								out_action_q <= 2'(ch_q);
								out_state_q  <= 8'(s0_q);
								out_end_q    <= END_RUNNING;
								out_eps_q    <= eps_q;
								out_value_q  <= '0;
							end
							K_FEED: begin
								state_q     <= sn_q;
								step_q      <= cnt[STEP_W] ? STEP_MAX : cnt[STEP_W-1:0];
								out_state_q <= 8'(sn_q);
								out_value_q <= newv_q;
								if (term_q) begin
									in_ep_q      <= 1'b0;
									action_q     <= '0;
									out_action_q <= '0;
									out_end_q    <= END_TERMINAL;
									if (eps_q > EPS_FLOOR) begin
										eps_q     <= eps_q - 1'b1;
										out_eps_q <= eps_q - 1'b1;
									end else begin
										out_eps_q <= eps_q;
									end
								end else if (cnt > {1'b0, limit_q}) begin
									in_ep_q      <= 1'b0;
									action_q     <= '0;
									out_action_q <= '0;
									out_end_q    <= END_LIMIT;
									out_eps_q    <= eps_q;
								end else begin
									action_q     <= ch_q;
									out_action_q <= 2'(ch_q);
									out_end_q    <= END_RUNNING;
									out_eps_q    <= eps_q;
								end
							end
							default: begin
								out_action_q <= 2'(action_q);
								out_state_q  <= 8'(state_q);
								out_end_q    <= END_RUNNING;
								out_eps_q    <= eps_q;
								out_value_q  <= '0;
							end
						endcase
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = out_action_q;
	assign current_state = out_state_q;
	assign episode_end   = out_end_q;
	assign epsilon_now   = out_eps_q;
	assign updated_value = out_value_q;

endmodule

// ===== design/tqsl_checker.sv =====
// ----------------------------------------------------------------------------
// tqsl_checker
// Port-level checks on the learner's output channel over time.
// ----------------------------------------------------------------------------
module tqsl_checker
	import tqsl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [1:0]            action,
	input logic [7:0]            current_state,
	input logic [1:0]            episode_end,
	input logic [EPS_W-1:0]      epsilon_now,
	input logic signed [Q_W-1:0] updated_value
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value, state and epsilon.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(updated_value) && $stable(current_state)
			&& $stable(epsilon_now))
		else $error("stalled result changed");

	// An ended episode reports action zero.
	a_end_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && episode_end != END_RUNNING |-> action == 2'd0)
		else $error("nonzero action at episode end");

	// The end code has only three meanings.
	a_end_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> episode_end == END_RUNNING || episode_end == END_TERMINAL
			|| episode_end == END_LIMIT)
		else $error("undefined episode end code");

endmodule

bind tabular_q_sarsa_learner_unit tqsl_checker u_tqsl_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tabular_q_sarsa_learner_unit: a behavioral learner
// tracks the Q table, episode state and exploration rate, and every transfer
// on the result channel is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import tqsl_pkg::*;

	localparam int NSTATES    = DEF_NUM_STATES;
	localparam int NACTIONS   = DEF_NUM_ACTIONS;
	localparam int CYCLE_CAP  = 1000000;
	localparam int DRAIN_WAIT = 20;
	localparam int HOLD_LEN   = 300;

	typedef struct packed {
		logic [1:0]           act;
		logic [7:0]           cur_state;
		logic [1:0]           end_code;
		logic [EPS_W-1:0]     eps;
		logic signed [Q_W-1:0] value;
	} learner_result_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic command;
	logic [7:0] start_state, next_state;
	logic signed [Q_W-1:0] reward;
	logic terminal;
	logic [EPS_W-1:0] explore_draw;
	logic [1:0] random_action;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] action;
	logic [7:0] current_state;
	logic [1:0] episode_end;
	logic [EPS_W-1:0] epsilon_now;
	logic signed [Q_W-1:0] updated_value;

	tabular_q_sarsa_learner_unit DUT (.*);

	// Shadow copy of the learner: table, episode registers and configuration.
	int q_shadow [NSTATES*NACTIONS];
	logic [7:0] cur_state_m;
	logic [1:0] cur_action_m;
	logic [EPS_W-1:0] eps_m;
	int unsigned steps_m;
	bit in_episode_m;
	logic [15:0] alpha_m, gamma_m;
	logic algo_m;
	logic [STEP_W-1:0] limit_m;

	learner_result_t pending_results[$];
	int errors;
	int send_gap_pct, recv_stall_pct;
	int hold_left = 0;
	logic hold_req;
	int cycles = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Run guard: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver side. A hold request loads a long stretch of continuous stall,
	// otherwise the stall is random at the rate the current phase asks for.
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result checker: every transfer on the output channel is compared with the
	// oldest outstanding prediction.
	always @(posedge clk) begin
		learner_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual act=%0d st=%0d end=%0d eps=%0d val=%0d",
					$time, action, current_state, episode_end, epsilon_now, updated_value);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (action !== want.act) begin
					$display("%0t: action expected %0d actual %0d", $time, want.act, action);
					errors++;
				end
				if (current_state !== want.cur_state) begin
					$display("%0t: current_state expected %0d actual %0d", $time,
						want.cur_state, current_state);
					errors++;
				end
				if (episode_end !== want.end_code) begin
					$display("%0t: episode_end expected %0d actual %0d", $time,
						want.end_code, episode_end);
					errors++;
				end
				if (epsilon_now !== want.eps) begin
					$display("%0t: epsilon_now expected %0d actual %0d", $time, want.eps, epsilon_now);
					errors++;
				end
				if (updated_value !== want.value) begin
					$display("%0t: updated_value expected %0d actual %0d", $time,
						want.value, updated_value);
					errors++;
				end
			end
		end
	end

	// Epsilon-greedy choice: explore below epsilon, else the first row maximum,
	// falling back to the random action when the whole row ties.
	function automatic logic [1:0] choose_action(int s, logic [EPS_W-1:0] draw, logic [1:0] rnd);
		int best;
		int idx;
		bit all_tied;
		if (draw < eps_m)
			return rnd;
		best = q_shadow[s*NACTIONS];
		idx = 0;
		all_tied = 1'b1;
		for (int k = 1; k < NACTIONS; k++) begin
			if (q_shadow[s*NACTIONS+k] != q_shadow[s*NACTIONS])
				all_tied = 1'b0;
			if (q_shadow[s*NACTIONS+k] > best) begin
				best = q_shadow[s*NACTIONS+k];
				idx = k;
			end
		end
		return all_tied ? rnd : idx[1:0];
	endfunction

	function automatic int row_peak(int s);
		int best;
		best = q_shadow[s*NACTIONS];
		for (int k = 1; k < NACTIONS; k++)
			if (q_shadow[s*NACTIONS+k] > best)
				best = q_shadow[s*NACTIONS+k];
		return best;
	endfunction

	// Applies one accepted input transfer to the shadow learner and queues the
	// result the block must produce for it.
	task automatic learner_predict();
		learner_result_t res;
		int s, a, ns;
		longint cur, target, err, nv;
		logic [1:0] next_act;
		int unsigned cnt;
		res.end_code = END_RUNNING;
		res.value = '0;
		ns = next_state;
		if (command == CMD_START) begin
			cur_state_m = start_state;
			steps_m = 0;
			in_episode_m = 1'b1;
			cur_action_m = choose_action(cur_state_m, explore_draw, random_action);
		end else if (in_episode_m) begin
			s = cur_state_m;
			a = cur_action_m;
			cur = q_shadow[s*NACTIONS+a];
			target = reward;
			next_act = '0;
			cnt = steps_m + 1;
			// SARSA picks the next action from the table before it is updated.
			if (algo_m == ALGO_SARSA) begin
				next_act = choose_action(ns, explore_draw, random_action);
				if (!terminal)
					target += (longint'(q_shadow[ns*NACTIONS+next_act]) * longint'(gamma_m)) >>> 16;
			end else begin
				target += (longint'(row_peak(ns)) * longint'(gamma_m)) >>> 16;
			end
			err = target - cur;
			nv = cur + ((err * longint'(alpha_m)) >>> 16);
			if (nv > 64'sd2147483647)
				nv = 64'sd2147483647;
			if (nv < -64'sd2147483648)
				nv = -64'sd2147483648;
			q_shadow[s*NACTIONS+a] = int'(nv);
			res.value = nv[31:0];
			if (algo_m == ALGO_QLEARN)
				next_act = choose_action(ns, explore_draw, random_action);
			cur_state_m = next_state;
			steps_m = (cnt > STEP_MAX) ? STEP_MAX : cnt;
			if (terminal) begin
				res.end_code = END_TERMINAL;
				if (eps_m > EPS_FLOOR)
					eps_m = eps_m - 1;
			end else if (cnt > limit_m) begin
				res.end_code = END_LIMIT;
			end
			if (res.end_code != END_RUNNING) begin
				in_episode_m = 1'b0;
				cur_action_m = '0;
			end else begin
				cur_action_m = next_act;
			end
		end
		res.act = cur_action_m;
		res.cur_state = cur_state_m;
		res.eps = eps_m;
		pending_results.push_back(res);
	endtask

	// Offers one item and returns at the edge where it is transferred. Valid is
	// left high so that back-to-back items need no second assignment.
	task automatic send_item(logic cmd, logic [7:0] st0, logic [7:0] nst,
			logic signed [31:0] rwd, logic term, logic [EPS_W-1:0] draw, logic [1:0] rnd);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		start_state <= st0;
		next_state <= nst;
		reward <= rwd;
		terminal <= term;
		explore_draw <= draw;
		random_action <= rnd;
		do @(posedge clk); while (in_stall);
		learner_predict();
	endtask

	// Waits until every result is back and the block has gone quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Writes all five registers on consecutive edges while the block is idle.
	task automatic set_config(logic [15:0] lr, logic [15:0] disc, logic [EPS_W-1:0] eps0,
			logic algo, logic [STEP_W-1:0] lim);
		logic [CFG_W-1:0] vals [5];
		logic [CFG_IW-1:0] idx [5];
		drain();
		vals = '{CFG_W'(lr), CFG_W'(disc), CFG_W'(eps0), CFG_W'(algo), lim};
		idx = '{CFG_LEARNING_RATE, CFG_DISCOUNT, CFG_EPSILON_START, CFG_ALGO_MODE, CFG_STEP_LIMIT};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		alpha_m = lr;
		gamma_m = disc;
		eps_m = eps0;
		algo_m = algo;
		limit_m = lim;
	endtask

	task automatic do_reset();
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_START;
		start_state <= '0;
		next_state <= '0;
		reward <= '0;
		terminal <= 1'b0;
		explore_draw <= '0;
		random_action <= '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		foreach (q_shadow[i])
			q_shadow[i] = 0;
		cur_state_m = '0;
		cur_action_m = '0;
		alpha_m = RST_LEARNING_RATE;
		gamma_m = RST_DISCOUNT;
		eps_m = RST_EPSILON;
		algo_m = ALGO_QLEARN;
		limit_m = RST_STEP_LIMIT;
		steps_m = 0;
		in_episode_m = 1'b0;
		// The table is cleared one row per cycle after reset; wait it out.
		do @(posedge clk); while (in_stall);
	endtask

	// Directed Q-learning: feedback outside an episode, extreme states and
	// rewards, exploration on and off, a step-limit end and a terminal end.
	task automatic test_directed_qlearn();
		set_config(16'hFFFF, 16'hFFFF, 7'd50, ALGO_QLEARN, 20'd2);
		send_item(CMD_FEEDBACK, 8'd9, 8'd9, 32'sd65536, 1'b0, 7'd0, 2'd1);
		send_item(CMD_START, 8'd255, 8'd0, 32'sd0, 1'b0, 7'd127, 2'd3);
		send_item(CMD_FEEDBACK, 8'd0, 8'd0, 32'h7FFFFFFF, 1'b0, 7'd0, 2'd2);
		send_item(CMD_FEEDBACK, 8'd0, 8'd255, 32'h80000000, 1'b0, 7'd99, 2'd0);
		send_item(CMD_FEEDBACK, 8'd0, 8'd255, 32'h7FFFFFFF, 1'b0, 7'd127, 2'd1);
		send_item(CMD_START, 8'd0, 8'd0, 32'sd0, 1'b0, 7'd98, 2'd2);
		send_item(CMD_FEEDBACK, 8'd0, 8'd255, 32'h7FFFFFFF, 1'b1, 7'd60, 2'd3);
		send_item(CMD_START, 8'd255, 8'd0, 32'sd0, 1'b0, 7'd0, 2'd0);
		send_item(CMD_FEEDBACK, 8'd0, 8'd0, 32'h80000000, 1'b1, 7'd127, 2'd1);
	endtask

	// Directed SARSA: a terminal step takes the reward alone, epsilon 127 explores
	// on every draw below 127, and epsilon stops decaying at its floor.
	task automatic test_directed_sarsa();
		set_config(16'd0, 16'd0, 7'd127, ALGO_SARSA, 20'hFFFFF);
		send_item(CMD_START, 8'd3, 8'd0, 32'sd0, 1'b0, 7'd126, 2'd2);
		send_item(CMD_FEEDBACK, 8'd0, 8'd3, 32'sd5, 1'b0, 7'd99, 2'd1);
		set_config(16'hFFFF, 16'h8000, 7'd3, ALGO_SARSA, 20'd1);
		send_item(CMD_START, 8'd3, 8'd0, 32'sd0, 1'b0, 7'd50, 2'd0);
		send_item(CMD_FEEDBACK, 8'd0, 8'd3, -32'sd131072, 1'b1, 7'd50, 2'd0);
		send_item(CMD_START, 8'd3, 8'd0, 32'sd0, 1'b0, 7'd50, 2'd3);
		send_item(CMD_FEEDBACK, 8'd0, 8'd3, 32'sd262144, 1'b1, 7'd1, 2'd2);
		send_item(CMD_START, 8'd3, 8'd0, 32'sd0, 1'b0, 7'd0, 2'd1);
		send_item(CMD_FEEDBACK, 8'd0, 8'd4, 32'sd65536, 1'b0, 7'd2, 2'd3);
		send_item(CMD_FEEDBACK, 8'd0, 8'd4, 32'sd65536, 1'b0, 7'd2, 2'd3);
	endtask

	// Random episodes: mostly well-formed start/feedback runs over a few states
	// so that rows are revisited, plus stray feedback and restarts.
	task automatic test_random_episodes(int n_items, bit narrow);
		int done_items;
		int r;
		logic cmd;
		logic signed [31:0] rwd;
		done_items = 0;
		while (done_items < n_items) begin
			r = $urandom_range(99);
			cmd = in_episode_m ? ((r < 4) ? CMD_START : CMD_FEEDBACK)
					: ((r < 90) ? CMD_START : CMD_FEEDBACK);
			if (cmd == CMD_START || in_episode_m)
				done_items++;
			case ($urandom_range(9))
				0: rwd = 32'h7FFFFFFF;
				1: rwd = 32'h80000000;
				2: rwd = $urandom;
				default: rwd = $signed($urandom_range(20) * 65536) - 32'sd655360;
			endcase
			send_item(cmd,
				narrow ? 8'($urandom_range(7)) : 8'($urandom_range(255)),
				narrow ? 8'($urandom_range(7)) : 8'($urandom_range(255)),
				rwd, $urandom_range(99) < 8,
				($urandom_range(99) < 90) ? 7'($urandom_range(98)) : 7'($urandom_range(127)),
				2'($urandom_range(3)));
		end
	endtask

	// Result channel held off for a long stretch while items keep coming, so
	// the block fills and pushes back on its input.
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		test_random_episodes(40, 1'b1);
	endtask

	initial begin
		errors = 0;
		hold_req = 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		do_reset();

		test_directed_qlearn();
		test_directed_sarsa();

		set_config(RST_LEARNING_RATE, RST_DISCOUNT, RST_EPSILON, ALGO_QLEARN, 20'd12);
		test_random_episodes(330, 1'b1);

		send_gap_pct = 81;
		set_config(16'hFFFF, 16'hFFFF, 7'd30, ALGO_SARSA, 20'd6);
		test_random_episodes(330, 1'b1);

		send_gap_pct = 0;
		recv_stall_pct = 81;
		set_config(16'h8000, 16'hC000, 7'd0, ALGO_QLEARN, 20'd1);
		test_random_episodes(330, 1'b0);

		send_gap_pct = 6;
		recv_stall_pct = 6;
		set_config(16'd0, 16'd0, 7'd100, ALGO_SARSA, 20'hFFFFF);
		test_random_episodes(300, 1'b1);

		set_config(16'd40000, 16'd65000, 7'd5, ALGO_QLEARN, 20'd20);
		test_random_episodes(300, 1'b1);

		test_backpressure();

		drain();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
design/tqsl_pkg.sv
design/tabular_q_sarsa_learner_unit.sv
design/tqsl_checker.sv
tb/tb.sv
